// ----- hw/rtl/stadium_path_frame_sampler_macros.svh -----
// Assertion macros shared by the RTL of the path frame sampler.
`ifndef STADIUM_PATH_FRAME_SAMPLER_MACROS_SVH
`define STADIUM_PATH_FRAME_SAMPLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPFS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- hw/rtl/spfs_pkg.sv -----
`default_nettype none

package spfs_pkg;

    // Pipeline geometry.
    localparam int INDEX_BITS    = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int DIV1_STEPS    = 31;
    localparam int DIV2_STEPS    = 32;
    localparam int ANGLE_FRAC    = 30;

    // Fixed-point constants.
    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [33:0] GAIN_Q30    = 34'd652032874;
    localparam logic [30:0] LEN_MAX     = 31'h7FFF_FFFF;
    localparam logic [15:0] MIN_SAMPLES = 16'd8;
    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

    // Configuration register indexes.
    localparam logic [2:0] REG_STRAIGHT = 3'd0;
    localparam logic [2:0] REG_RADIUS   = 3'd1;
    localparam logic [2:0] REG_HWIDTH   = 3'd2;
    localparam logic [2:0] REG_ELEV     = 3'd3;
    localparam logic [2:0] REG_COUNT    = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADCFG = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    typedef enum logic [1:0] {
        SEG_UP,
        SEG_TURN_A,
        SEG_DOWN,
        SEG_TURN_B
    } seg_t;

    // Payload that travels down the chain of cells.
    typedef struct packed {
        logic [INDEX_BITS-1:0] idx;
        logic [1:0]            status;
        seg_t                  seg;
        logic                  flip;
        logic [30:0]           d;
        logic [30:0]           dd;
        logic [33:0]           rem;
        logic [31:0]           quo;
        logic [31:0]           num;
        logic [31:0]           dvs;
        logic signed [33:0]    x;
        logic signed [33:0]    y;
        logic signed [33:0]    z;
    } item_t;

    // Arctangent of 2^-i in Q2.30.
    function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
        logic signed [33:0] v;
        begin
            case (i)
                5'd0:  v = 34'sd843314857;
                5'd1:  v = 34'sd497837829;
                5'd2:  v = 34'sd263043837;
                5'd3:  v = 34'sd133525159;
                5'd4:  v = 34'sd67021687;
                5'd5:  v = 34'sd33543516;
                5'd6:  v = 34'sd16775851;
                5'd7:  v = 34'sd8388437;
                5'd8:  v = 34'sd4194283;
                5'd9:  v = 34'sd2097149;
                5'd10: v = 34'sd1048576;
                5'd11: v = 34'sd524288;
                5'd12: v = 34'sd262144;
                5'd13: v = 34'sd131072;
                5'd14: v = 34'sd65536;
                5'd15: v = 34'sd32768;
                5'd16: v = 34'sd16384;
                5'd17: v = 34'sd8192;
                5'd18: v = 34'sd4096;
                5'd19: v = 34'sd2048;
                5'd20: v = 34'sd1024;
                5'd21: v = 34'sd512;
                5'd22: v = 34'sd256;
                5'd23: v = 34'sd128;
                default: v = 34'sd0;
            endcase
            return v;
        end
    endfunction

    // Round a Q2.30 value to Q2.14 and clamp to the unit range.
    function automatic logic signed [15:0] to_q14(input logic signed [35:0] v);
        logic signed [35:0] t;
        logic signed [15:0] r;
        begin
            t = (v + 36'sd32768) >>> 16;
            if (t > 36'sd16384)
            begin
                r = ONE_Q14;
            end
            else if (t < -36'sd16384)
            begin
                r = -ONE_Q14;
            end
            else
            begin
                r = t[15:0];
            end
            return r;
        end
    endfunction

    // Saturate to a signed 32-bit value.
    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        begin
            if (v > 68'sd2147483647)
            begin
                r = 32'sh7FFF_FFFF;
            end
            else if (v < -68'sd2147483648)
            begin
                r = 32'sh8000_0000;
            end
            else
            begin
                r = v[31:0];
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/stadium_path_frame_sampler.sv -----
// Throughput: one sample index per cycle unless out_stall holds a full output register;
// the whole chain of cells advances together.
// The depth comes from the 31-step distance divider, the 32-step angle divider
// and the 16-step CORDIC row, one bit or rotation per cell.
// Reset: asynchronous, active low; clears all valid flags and loads the default registers.
`default_nettype none

`include "stadium_path_frame_sampler_macros.svh"

module stadium_path_frame_sampler (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [2:0]                            cfg_index,
    input  wire logic [31:0]                           cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [spfs_pkg::INDEX_BITS-1:0]       sample_index,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [30:0]                                arc_distance,
    output logic signed [31:0]                         pos_x,
    output logic signed [31:0]                         pos_y,
    output logic signed [31:0]                         pos_z,
    output logic signed [15:0]                         forward_x,
    output logic signed [15:0]                         forward_z,
    output logic signed [15:0]                         right_x,
    output logic signed [15:0]                         right_z,
    output logic [30:0]                                width_out,
    output logic [1:0]                                 status
);
    import spfs_pkg::*;

    // Configuration registers and derived loop lengths.
    logic [30:0]        straight_reg;
    logic [30:0]        radius_reg;
    logic [30:0]        hwidth_reg;
    logic signed [31:0] elev_reg;
    logic [15:0]        count_reg;
    logic [32:0]        tl_reg;
    logic [32:0]        tl_next;
    logic [30:0]        len_reg;
    logic [30:0]        len_next;
    logic [63:0]        tl_prod;
    logic [63:0]        tl_sum;
    logic [34:0]        len_sum;

    logic en;
    logic accept;

    // Front stages.
    logic  a_valid_reg;
    item_t a_item_reg;
    item_t a_item_next;
    logic  b_valid_reg;
    item_t b_item_reg;
    logic  c_valid_reg;
    item_t c_item_reg;
    logic [46:0] c_prod_reg;
    logic [46:0] c_prod_next;

    // Cell rows.
    logic  d1_valid [0:DIV1_STEPS];
    item_t d1_item  [0:DIV1_STEPS];
    logic  d2_valid [0:DIV2_STEPS];
    item_t d2_item  [0:DIV2_STEPS];
    logic  cr_valid [0:CORDIC_STAGES];
    item_t cr_item  [0:CORDIC_STAGES];

    // Segment stage and angle stage.
    logic  sg_valid_reg;
    item_t sg_item_reg;
    item_t sg_item_next;
    logic [33:0] s_tl;
    logic [33:0] two_s_tl;
    logic [33:0] d34;
    logic [33:0] dd34;
    logic  an_valid_reg;
    item_t an_item_reg;
    item_t an_item_next;
    logic [31:0] ang_c;

    // Back stages.
    logic  pa_valid_reg;
    item_t pa_item_reg;
    item_t pa_item_next;
    logic  pb_valid_reg;
    item_t pb_item_reg;
    logic signed [65:0] mc_reg;
    logic signed [65:0] ms_reg;
    logic signed [65:0] mc_next;
    logic signed [65:0] ms_next;

    // Output register.
    logic               out_valid_reg;
    logic [30:0]        dist_reg;
    logic signed [31:0] px_reg;
    logic signed [31:0] py_reg;
    logic signed [31:0] pz_reg;
    logic signed [15:0] fx_reg;
    logic signed [15:0] fz_reg;
    logic signed [15:0] rx_reg;
    logic signed [15:0] rz_reg;
    logic [30:0]        wid_reg;
    logic [1:0]         st_reg;
    logic [30:0]        dist_next;
    logic signed [31:0] px_next;
    logic signed [31:0] py_next;
    logic signed [31:0] pz_next;
    logic signed [15:0] fx_next;
    logic signed [15:0] fz_next;
    logic signed [15:0] rx_next;
    logic signed [15:0] rz_next;
    logic [30:0]        wid_next;
    logic signed [67:0] hs68;
    logic signed [67:0] dd68;
    logic signed [67:0] r68;
    logic signed [67:0] cx68;
    logic signed [67:0] sz68;
    logic signed [35:0] c36;
    logic signed [35:0] s36;
    logic               err_fields_zero;

    // The chain moves whenever the output register is free or being emptied.
    assign en        = !(out_valid_reg && out_stall);
    assign in_stall  = !en;
    assign accept    = in_valid && en;
    assign cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            straight_reg <= 31'd6553600;
            radius_reg   <= 31'd3276800;
            hwidth_reg   <= 31'd655360;
            elev_reg     <= 32'sd0;
            count_reg    <= 16'd1024;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_STRAIGHT: straight_reg <= cfg_data[30:0];
                REG_RADIUS:   radius_reg   <= cfg_data[30:0];
                REG_HWIDTH:   hwidth_reg   <= cfg_data[30:0];
                REG_ELEV:     elev_reg     <= cfg_data;
                REG_COUNT:    count_reg    <= cfg_data[15:0];
                default:      ;
            endcase
        end
    end

    // Turn length round(R*pi) and saturated loop length, refreshed every cycle.
    always_comb
    begin
        tl_prod  = 64'(radius_reg) * 64'(PI_Q30);
        tl_sum   = tl_prod + 64'(1 << (ANGLE_FRAC - 1));
        tl_next  = tl_sum[62:30];
        len_sum  = {3'b000, straight_reg, 1'b0} + {1'b0, tl_reg, 1'b0};
        len_next = (len_sum > 35'(LEN_MAX)) ? LEN_MAX : len_sum[30:0];
    end

    always_ff @(posedge clk)
    begin
        tl_reg  <= tl_next;
        len_reg <= len_next;
    end

    // Accept stage: classify the configuration and the index.
    always_comb
    begin
        a_item_next        = '0;
        a_item_next.idx    = sample_index;
        if (straight_reg == '0 || hwidth_reg == '0 || radius_reg <= hwidth_reg
            || count_reg < MIN_SAMPLES)
        begin
            a_item_next.status = ST_BADCFG;
        end
        else if (16'(sample_index) >= count_reg)
        begin
            a_item_next.status = ST_RANGE;
        end
        else
        begin
            a_item_next.status = ST_OK;
        end
    end

    assign c_prod_next = 47'(len_reg) * 47'(b_item_reg.idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_item_reg <= a_item_next;
            b_item_reg <= a_item_reg;
            c_item_reg <= b_item_reg;
            c_prod_reg <= c_prod_next;
        end
    end

    // Distance divider: d = len*idx / count, one quotient bit per cell.
    always_comb
    begin
        d1_valid[0]     = c_valid_reg;
        d1_item[0]      = c_item_reg;
        d1_item[0].rem  = {18'd0, c_prod_reg[46:31]};
        d1_item[0].num  = {c_prod_reg[30:0], 1'b0};
        d1_item[0].dvs  = {16'd0, count_reg};
        d1_item[0].quo  = '0;
    end

    for (genvar i = 0; i < DIV1_STEPS; i++)
    begin : g_div1
        spfs_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (d1_valid[i]),
            .in_item   (d1_item[i]),
            .out_valid (d1_valid[i+1]),
            .out_item  (d1_item[i+1])
        );
    end

    // Segment stage: find the segment and the distance into it.
    always_comb
    begin
        sg_item_next   = d1_item[DIV1_STEPS];
        sg_item_next.d = d1_item[DIV1_STEPS].quo[30:0];
        d34            = {3'b000, d1_item[DIV1_STEPS].quo[30:0]};
        s_tl           = {3'b000, straight_reg} + {1'b0, tl_reg};
        two_s_tl       = {2'b00, straight_reg, 1'b0} + {1'b0, tl_reg};
        if (d34 < {3'b000, straight_reg})
        begin
            sg_item_next.seg = SEG_UP;
            dd34             = d34;
        end
        else if (d34 < s_tl)
        begin
            sg_item_next.seg = SEG_TURN_A;
            dd34             = d34 - {3'b000, straight_reg};
        end
        else if (d34 < two_s_tl)
        begin
            sg_item_next.seg = SEG_DOWN;
            dd34             = d34 - s_tl;
        end
        else
        begin
            sg_item_next.seg = SEG_TURN_B;
            dd34             = d34 - two_s_tl;
        end
        sg_item_next.dd = dd34[30:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sg_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sg_valid_reg <= d1_valid[DIV1_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sg_item_reg <= sg_item_next;
        end
    end

    // Angle divider: a = (dd << 30) / R.
    always_comb
    begin
        d2_valid[0]    = sg_valid_reg;
        d2_item[0]     = sg_item_reg;
        d2_item[0].rem = {5'd0, sg_item_reg.dd[30:2]};
        d2_item[0].num = {sg_item_reg.dd[1:0], 30'd0};
        d2_item[0].dvs = {1'b0, radius_reg};
        d2_item[0].quo = '0;
    end

    for (genvar i = 0; i < DIV2_STEPS; i++)
    begin : g_div2
        spfs_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (d2_valid[i]),
            .in_item   (d2_item[i]),
            .out_valid (d2_valid[i+1]),
            .out_item  (d2_item[i+1])
        );
    end

    // Angle stage: clamp to pi and fold into the first quadrant.
    always_comb
    begin
        an_item_next = d2_item[DIV2_STEPS];
        ang_c = (d2_item[DIV2_STEPS].quo > PI_Q30) ? PI_Q30 : d2_item[DIV2_STEPS].quo;
        an_item_next.flip = (ang_c > HALF_PI_Q30);
        an_item_next.x    = GAIN_Q30;
        an_item_next.y    = '0;
        if (ang_c > HALF_PI_Q30)
        begin
            an_item_next.z = $signed({2'b00, PI_Q30 - ang_c});
        end
        else
        begin
            an_item_next.z = $signed({2'b00, ang_c});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            an_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            an_valid_reg <= d2_valid[DIV2_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            an_item_reg <= an_item_next;
        end
    end

    // CORDIC row, one rotation per cell.
    assign cr_valid[0] = an_valid_reg;
    assign cr_item[0]  = an_item_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        spfs_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .shift     (5'(i)),
            .in_valid  (cr_valid[i]),
            .in_item   (cr_item[i]),
            .out_valid (cr_valid[i+1]),
            .out_item  (cr_item[i+1])
        );
    end

    // Unfold the quadrant and mirror for the second turn: x holds cos, y holds sin.
    always_comb
    begin
        pa_item_next = cr_item[CORDIC_STAGES];
        if (cr_item[CORDIC_STAGES].flip)
        begin
            pa_item_next.x = -cr_item[CORDIC_STAGES].x;
        end
        if (cr_item[CORDIC_STAGES].seg == SEG_TURN_B)
        begin
            pa_item_next.x = -pa_item_next.x;
            pa_item_next.y = -cr_item[CORDIC_STAGES].y;
        end
    end

    // Radius times cosine and sine.
    assign mc_next = $signed({1'b0, radius_reg}) * pa_item_reg.x;
    assign ms_next = $signed({1'b0, radius_reg}) * pa_item_reg.y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pa_valid_reg <= 1'b0;
            pb_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pa_valid_reg <= cr_valid[CORDIC_STAGES];
            pb_valid_reg <= pa_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_item_reg <= pa_item_next;
            pb_item_reg <= pa_item_reg;
            mc_reg      <= mc_next;
            ms_reg      <= ms_next;
        end
    end

    // Final stage: position, unit vectors and status masking.
    always_comb
    begin
        hs68 = $signed({38'd0, straight_reg[30:1]});
        dd68 = $signed({37'd0, pb_item_reg.dd});
        r68  = $signed({37'd0, radius_reg});
        cx68 = ($signed({{2{mc_reg[65]}}, mc_reg}) + 68'sd536870912) >>> ANGLE_FRAC;
        sz68 = ($signed({{2{ms_reg[65]}}, ms_reg}) + 68'sd536870912) >>> ANGLE_FRAC;
        c36  = pb_item_reg.x;
        s36  = pb_item_reg.y;
        case (pb_item_reg.seg)
            SEG_UP:
            begin
                px_next = sat32(r68);
                pz_next = sat32(dd68 - hs68);
                fx_next = '0;
                fz_next = ONE_Q14;
                rx_next = ONE_Q14;
                rz_next = '0;
            end
            SEG_DOWN:
            begin
                px_next = sat32(-r68);
                pz_next = sat32(hs68 - dd68);
                fx_next = '0;
                fz_next = -ONE_Q14;
                rx_next = -ONE_Q14;
                rz_next = '0;
            end
            SEG_TURN_A:
            begin
                px_next = sat32(cx68);
                pz_next = sat32(hs68 + sz68);
                fx_next = to_q14(-s36);
                fz_next = to_q14(c36);
                rx_next = to_q14(c36);
                rz_next = to_q14(s36);
            end
            default:
            begin
                px_next = sat32(cx68);
                pz_next = sat32(sz68 - hs68);
                fx_next = to_q14(-s36);
                fz_next = to_q14(c36);
                rx_next = to_q14(c36);
                rz_next = to_q14(s36);
            end
        endcase
        dist_next = pb_item_reg.d;
        py_next   = elev_reg;
        wid_next  = hwidth_reg;
        if (pb_item_reg.status != ST_OK)
        begin
            dist_next = '0;
            px_next   = '0;
            py_next   = '0;
            pz_next   = '0;
            fx_next   = '0;
            fz_next   = '0;
            rx_next   = '0;
            rz_next   = '0;
            wid_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= pb_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg <= dist_next;
            px_reg   <= px_next;
            py_reg   <= py_next;
            pz_reg   <= pz_next;
            fx_reg   <= fx_next;
            fz_reg   <= fz_next;
            rx_reg   <= rx_next;
            rz_reg   <= rz_next;
            wid_reg  <= wid_next;
            st_reg   <= pb_item_reg.status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign arc_distance = dist_reg;
    assign pos_x        = px_reg;
    assign pos_y        = py_reg;
    assign pos_z        = pz_reg;
    assign forward_x    = fx_reg;
    assign forward_z    = fz_reg;
    assign right_x      = rx_reg;
    assign right_z      = rz_reg;
    assign width_out    = wid_reg;
    assign status       = st_reg;

    // An error result carries zero in its geometry fields.
    assign err_fields_zero = (px_reg == 32'sd0 && pz_reg == 32'sd0
                              && fz_reg == 16'sd0 && wid_reg == 31'd0);

    // Checks on the result path.
    `SPFS_ASSERT_IMPLY(a_status_code, clk, rst_n, out_valid_reg, (st_reg != 2'd3))
    `SPFS_ASSERT_IMPLY(a_error_zero, clk, rst_n, (out_valid_reg && st_reg != ST_OK), err_fields_zero)
    `SPFS_ASSERT_IMPLY(a_cos_shared, clk, rst_n, out_valid_reg, (fz_reg == rx_reg))
    `SPFS_ASSERT_NEXT(a_accept_enters, clk, rst_n, accept, a_valid_reg)

endmodule

`default_nettype wire

// ----- hw/rtl/spfs_div_cell.sv -----
`default_nettype none

// One restoring division step: shift in one dividend bit, subtract if it fits.
module spfs_div_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire spfs_pkg::item_t in_item,
    output logic                out_valid,
    output spfs_pkg::item_t     out_item
);
    import spfs_pkg::*;

    logic        valid_reg;
    item_t       item_reg;
    item_t       item_next;
    logic [33:0] shifted;
    logic [33:0] divisor;
    logic        fits;

    // Trial subtraction of the divisor.
    always_comb
    begin
        shifted   = {in_item.rem[32:0], in_item.num[31]};
        divisor   = {2'b00, in_item.dvs};
        fits      = (shifted >= divisor);
        item_next = in_item;
        item_next.rem = fits ? (shifted - divisor) : shifted;
        item_next.quo = {in_item.quo[30:0], fits};
        item_next.num = {in_item.num[30:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/spfs_cordic_cell.sv -----
`default_nettype none

// One CORDIC rotation step at the shift given by the cell's place in the row.
module spfs_cordic_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic [4:0]     shift,
    input  wire logic           in_valid,
    input  wire spfs_pkg::item_t in_item,
    output logic                out_valid,
    output spfs_pkg::item_t     out_item
);
    import spfs_pkg::*;

    logic               valid_reg;
    item_t              item_reg;
    item_t              item_next;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] ang;

    // Rotate toward zero residual angle.
    always_comb
    begin
        dx        = in_item.y >>> shift;
        dy        = in_item.x >>> shift;
        ang       = atan_entry(shift);
        item_next = in_item;
        if (!in_item.z[33])
        begin
            item_next.x = in_item.x - dx;
            item_next.y = in_item.y + dy;
            item_next.z = in_item.z - ang;
        end
        else
        begin
            item_next.x = in_item.x + dx;
            item_next.y = in_item.y - dy;
            item_next.z = in_item.z + ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import spfs_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    // Fixed-point constants of the loop geometry.
    localparam longint PI_Q30_L      = 64'd3373259426;
    localparam longint HALF_PI_Q30_L = 64'd1686629713;
    localparam longint GAIN_Q30_L    = 64'd652032874;
    localparam longint UNIT_Q14      = 64'd16384;
    localparam longint LOOP_MAX      = 64'd2147483647;

    typedef struct {
        logic [30:0]        arc;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [15:0] fx;
        logic signed [15:0] fz;
        logic signed [15:0] rx;
        logic signed [15:0] rz;
        logic [30:0]        width;
        logic [1:0]         st;
    } frame_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [INDEX_BITS-1:0] sample_index;
    logic out_valid;
    logic out_stall;
    logic [30:0] arc_distance;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] forward_x;
    logic signed [15:0] forward_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_z;
    logic [30:0] width_out;
    logic [1:0] status;

    // Mirror of the block's registers.
    longint straight_q;
    longint radius_q;
    longint hwidth_q;
    longint elev_q;
    longint count_q;

    frame_t pending_frames[$];
    int errors = 0;
    int cycles = 0;
    int gap_pct;
    int stall_pct;

    stadium_path_frame_sampler dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sample_index(sample_index),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .arc_distance(arc_distance),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .pos_z(pos_z),
        .forward_x(forward_x),
        .forward_z(forward_z),
        .right_x(right_x),
        .right_z(right_z),
        .width_out(width_out),
        .status(status)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Run time guard.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Rotation-mode CORDIC for an angle in [0, pi], Q2.30 in and out.
    function automatic void rotate_angle(input longint ang, output longint c, output longint s);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit mirror;
        begin
            x = GAIN_Q30_L;
            y = 0;
            mirror = 0;
            if (ang < 0)
                ang = 0;
            if (ang > PI_Q30_L)
                ang = PI_Q30_L;
            if (ang > HALF_PI_Q30_L)
            begin
                ang = PI_Q30_L - ang;
                mirror = 1;
            end
            z = ang;
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - longint'(atan_entry(i[4:0]));
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + longint'(atan_entry(i[4:0]));
                end
            end
            c = mirror ? -x : x;
            s = y;
        end
    endfunction

    // Q2.30 to Q2.14 with rounding, clamped to the unit range.
    function automatic longint unit_q14(input longint v);
        longint r;
        begin
            r = (v + 32768) >>> 16;
            if (r > UNIT_Q14)
                r = UNIT_Q14;
            if (r < -UNIT_Q14)
                r = -UNIT_Q14;
            return r;
        end
    endfunction

    function automatic longint clamp32(input longint v);
        begin
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        end
    endfunction

    // Frame on the stadium loop for one sample index under the current registers.
    function automatic frame_t frame_at(input longint idx);
        frame_t f;
        longint turn_len;
        longint loop_len;
        longint d;
        longint half_s;
        longint px;
        longint pz;
        longint c;
        longint sn;
        longint ang;
        longint fx;
        longint fz;
        longint rx;
        longint rz;
        begin
            f = '{default: '0};
            if (straight_q == 0 || hwidth_q == 0 || radius_q <= hwidth_q
                || count_q < 8)
            begin
                f.st = ST_BADCFG;
                return f;
            end
            if (idx >= count_q)
            begin
                f.st = ST_RANGE;
                return f;
            end
            turn_len = (radius_q * PI_Q30_L + (64'd1 << 29)) >> 30;
            loop_len = 2 * straight_q + 2 * turn_len;
            if (loop_len > LOOP_MAX)
                loop_len = LOOP_MAX;
            d = loop_len * idx / count_q;
            half_s = straight_q >> 1;
            if (d < straight_q)
            begin
                // Straight along +z.
                px = radius_q;
                pz = -half_s + d;
                fx = 0;
                fz = UNIT_Q14;
                rx = UNIT_Q14;
                rz = 0;
            end
            else if (d < straight_q + turn_len)
            begin
                // Turn from angle zero.
                ang = ((d - straight_q) << 30) / radius_q;
                rotate_angle(ang, c, sn);
                px = (radius_q * c + (64'sd1 << 29)) >>> 30;
                pz = half_s + ((radius_q * sn + (64'sd1 << 29)) >>> 30);
                fx = unit_q14(-sn);
                fz = unit_q14(c);
                rx = unit_q14(c);
                rz = unit_q14(sn);
            end
            else if (d < 2 * straight_q + turn_len)
            begin
                // Straight along -z.
                px = -radius_q;
                pz = half_s - (d - straight_q - turn_len);
                fx = 0;
                fz = -UNIT_Q14;
                rx = -UNIT_Q14;
                rz = 0;
            end
            else
            begin
                // Turn from angle pi.
                ang = ((d - 2 * straight_q - turn_len) << 30) / radius_q;
                rotate_angle(ang, c, sn);
                c = -c;
                sn = -sn;
                px = (radius_q * c + (64'sd1 << 29)) >>> 30;
                pz = -half_s + ((radius_q * sn + (64'sd1 << 29)) >>> 30);
                fx = unit_q14(-sn);
                fz = unit_q14(c);
                rx = unit_q14(c);
                rz = unit_q14(sn);
            end
            f.arc = d[30:0];
            f.px = clamp32(px);
            f.py = elev_q[31:0];
            f.pz = clamp32(pz);
            f.fx = fx[15:0];
            f.fz = fz[15:0];
            f.rx = rx[15:0];
            f.rz = rz[15:0];
            f.width = hwidth_q[30:0];
            f.st = ST_OK;
            return f;
        end
    endfunction

    function automatic void compare_field(input string name, input longint want,
                                          input longint got);
        begin
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        end
    endfunction

    // Receiver stall pattern.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Result checker: each output transfer against the oldest expected frame.
    always @(posedge clk)
    begin
        frame_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_frames.size() == 0)
            begin
                $error("result transfer with no expected frame");
                errors++;
            end
            else
            begin
                w = pending_frames.pop_front();
                compare_field("arc_distance", w.arc, arc_distance);
                compare_field("pos_x", w.px, pos_x);
                compare_field("pos_y", w.py, pos_y);
                compare_field("pos_z", w.pz, pos_z);
                compare_field("forward_x", w.fx, forward_x);
                compare_field("forward_z", w.fz, forward_z);
                compare_field("right_x", w.rx, right_x);
                compare_field("right_z", w.rz, right_z);
                compare_field("width_out", w.width, width_out);
                compare_field("status", w.st, status);
            end
        end
    end

    // Send one sample index; the expected frame is queued at the transfer.
    task automatic send_index(input logic [15:0] idx);
        int gap;
        begin
            if ($urandom_range(99) < gap_pct)
            begin
                gap = $urandom_range(1, 4);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            sample_index <= idx;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            pending_frames.insert(pending_frames.size(), frame_at(longint'(idx)));
        end
    endtask

    task automatic drain_results();
        begin
            in_valid <= 1'b0;
            while (pending_frames.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    // Register write, issued only with the pipeline empty.
    task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
        begin
            drain_results();
            cfg_valid <= 1'b1;
            cfg_index <= index;
            cfg_data <= data;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cfg_valid <= 1'b0;
            case (index)
                REG_STRAIGHT: straight_q = data[30:0];
                REG_RADIUS:   radius_q = data[30:0];
                REG_HWIDTH:   hwidth_q = data[30:0];
                REG_ELEV:     elev_q = longint'(signed'(data));
                REG_COUNT:    count_q = data[15:0];
                default: ;
            endcase
        end
    endtask

    task automatic load_geometry(input logic [31:0] s, input logic [31:0] r,
                                 input logic [31:0] hw, input logic [31:0] el,
                                 input logic [31:0] n);
        begin
            write_reg(REG_STRAIGHT, s);
            write_reg(REG_RADIUS, r);
            write_reg(REG_HWIDTH, hw);
            write_reg(REG_ELEV, el);
            write_reg(REG_COUNT, n);
        end
    endtask

    // Default geometry: ends of the index range and points near segment joins.
    task automatic test_default_frames();
        begin
            send_index(16'd0);
            send_index(16'd1);
            send_index(16'd200);
            send_index(16'd400);
            send_index(16'd512);
            send_index(16'd600);
            send_index(16'd700);
            send_index(16'd900);
            send_index(16'd1023);
            send_index(16'd1024);
            send_index(16'hFFFF);
        end
    endtask

    // Extremes of the registers: saturated loop length and full-scale fields.
    task automatic test_register_extremes();
        begin
            load_geometry(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                          32'd65535);
            send_index(16'd0);
            send_index(16'd16384);
            send_index(16'd40000);
            send_index(16'd65534);
            send_index(16'd65535);
            load_geometry(32'h8000_0001, 32'd3, 32'd2, 32'h7FFF_FFFF, 32'd8);
            send_index(16'd0);
            send_index(16'd5);
            send_index(16'd7);
            send_index(16'd8);
        end
    endtask

    // Each way the geometry can be rejected.
    task automatic test_bad_geometry();
        begin
            load_geometry(32'd0, 32'd3276800, 32'd655360, 32'd0, 32'd1024);
            send_index(16'd3);
            load_geometry(32'd6553600, 32'd3276800, 32'd0, 32'd0, 32'd1024);
            send_index(16'd3);
            load_geometry(32'd6553600, 32'd655360, 32'd655360, 32'd0, 32'd1024);
            send_index(16'd3);
            load_geometry(32'd6553600, 32'd3276800, 32'd655360, 32'd0, 32'd7);
            send_index(16'd3);
            send_index(16'd9);
        end
    endtask

    function automatic logic [31:0] pick_length(input int hi_bits);
        begin
            return {1'($urandom_range(1)), 31'($urandom_range(1, (1 << hi_bits) - 1))};
        end
    endfunction

    // Random geometries and indices under one idling pattern.
    task automatic test_random_frames(input int gaps, input int stalls, input int n_items);
        logic [31:0] s;
        logic [31:0] r;
        logic [31:0] hw;
        logic [31:0] n;
        logic [15:0] idx;
        begin
            gap_pct = gaps;
            stall_pct = stalls;
            for (int k = 0; k < n_items; k++)
            begin
                if (k % 32 == 0)
                begin
                    case ($urandom_range(5))
                        0: s = {1'($urandom_range(1)), 31'($urandom)};
                        default: s = pick_length(26);
                    endcase
                    hw = pick_length(22);
                    if ($urandom_range(3) == 0)
                        r = {1'($urandom_range(1)), 31'($urandom) | 31'h4000_0000};
                    else
                        r = {1'b0, hw[30:0]} + 32'($urandom_range(1, 1 << 25));
                    if ($urandom_range(9) == 0)
                        r = hw;
                    case ($urandom_range(7))
                        0: n = 32'd65535;
                        1: n = 32'($urandom_range(0, 7));
                        default: n = {16'($urandom), 16'($urandom_range(8, 2000))};
                    endcase
                    load_geometry(s, r, hw, $urandom, n);
                end
                if (count_q > 0 && $urandom_range(9) < 8)
                    idx = 16'($urandom_range(0, count_q - 1));
                else
                    idx = 16'($urandom);
                send_index(idx);
            end
            drain_results();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_STRAIGHT;
        cfg_data = '0;
        in_valid = 1'b0;
        sample_index = '0;
        gap_pct = 0;
        stall_pct = 0;
        straight_q = 6553600;
        radius_q = 3276800;
        hwidth_q = 655360;
        elev_q = 0;
        count_q = 1024;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_frames();
        test_register_extremes();
        test_bad_geometry();
        test_random_frames(0, 0, 160);
        test_random_frames(50, 0, 160);
        test_random_frames(0, 50, 160);
        test_random_frames(27, 27, 160);

        // Let anything stray come out of the pipeline.
        repeat (100) @(posedge clk);
        if (errors == 0 && pending_frames.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
